FILE: src/akwv_pkg.sv
// ----------------------------------------------------------------------------
// akwv_pkg
// Key codes, payload structs, register indexes and ladder voltage windows.
// ----------------------------------------------------------------------------
package akwv_pkg;

	typedef enum logic [2:0] {
		BTN_NONE   = 3'd0,
		BTN_UP     = 3'd1,
		BTN_DOWN   = 3'd2,
		BTN_LEFT   = 3'd3,
		BTN_RIGHT  = 3'd4,
		BTN_MIDDLE = 3'd5
	} key_t;

	localparam int unsigned NUM_BUTTONS   = 6;
	localparam int unsigned SAMPLE_WIDTH  = 12;
	localparam int unsigned ELAPSED_WIDTH = 16;
	localparam int unsigned CFG_WIDTH     = 16;

	typedef enum logic {
		REG_LAYOUT_SELECT = 1'b0,
		REG_WINDOW_MS     = 1'b1
	} reg_index_t;

	localparam logic [ELAPSED_WIDTH-1:0] WINDOW_MS_RESET = 16'd10;

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] adc_sample;
		logic                    ms_tick;
	} sample_t;

	typedef struct packed {
		logic event_valid;
		key_t event_key;
		key_t current_key;
	} result_t;

	typedef struct packed {
		logic match;
		key_t key;
	} class_t;

	// ladder windows, bounds exclusive
	localparam logic [SAMPLE_WIDTH-1:0] DEF_NONE_LO   = 12'd4000;
	localparam logic [SAMPLE_WIDTH-1:0] ALT_NONE_LO   = 12'd3900;
	localparam logic [SAMPLE_WIDTH-1:0] WIN_A_LO      = 12'd2300;
	localparam logic [SAMPLE_WIDTH-1:0] WIN_A_HI      = 12'd2500;
	localparam logic [SAMPLE_WIDTH-1:0] WIN_LOW_HI    = 12'd300;
	localparam logic [SAMPLE_WIDTH-1:0] WIN_B_LO      = 12'd2600;
	localparam logic [SAMPLE_WIDTH-1:0] WIN_B_HI      = 12'd3000;
	localparam logic [SAMPLE_WIDTH-1:0] DEF_C_LO      = 12'd1000;
	localparam logic [SAMPLE_WIDTH-1:0] DEF_C_HI      = 12'd1600;
	localparam logic [SAMPLE_WIDTH-1:0] ALT_C_LO      = 12'd1200;
	localparam logic [SAMPLE_WIDTH-1:0] ALT_C_HI      = 12'd1700;
	localparam logic [SAMPLE_WIDTH-1:0] WIN_MID_LO    = 12'd3200;
	localparam logic [SAMPLE_WIDTH-1:0] WIN_MID_HI    = 12'd3400;

endpackage

FILE: src/akwv_classify.sv
// ----------------------------------------------------------------------------
// akwv_classify
// Maps one ladder sample to a key through the window table of the layout.
// ----------------------------------------------------------------------------
module akwv_classify (
	input  logic [akwv_pkg::SAMPLE_WIDTH-1:0] adc_sample,
	input  logic                              layout_select,
	output akwv_pkg::class_t                  cls
);

	logic [akwv_pkg::SAMPLE_WIDTH-1:0] none_lo;
	logic [akwv_pkg::SAMPLE_WIDTH-1:0] c_lo;
	logic [akwv_pkg::SAMPLE_WIDTH-1:0] c_hi;
	logic in_none;
	logic in_a;
	logic in_low;
	logic in_b;
	logic in_c;
	logic in_mid;

	assign none_lo = layout_select ? akwv_pkg::ALT_NONE_LO : akwv_pkg::DEF_NONE_LO;
	assign c_lo    = layout_select ? akwv_pkg::ALT_C_LO : akwv_pkg::DEF_C_LO;
	assign c_hi    = layout_select ? akwv_pkg::ALT_C_HI : akwv_pkg::DEF_C_HI;

	assign in_none = adc_sample > none_lo;
	assign in_a    = (adc_sample > akwv_pkg::WIN_A_LO) && (adc_sample < akwv_pkg::WIN_A_HI);
	assign in_low  = adc_sample < akwv_pkg::WIN_LOW_HI;
	assign in_b    = (adc_sample > akwv_pkg::WIN_B_LO) && (adc_sample < akwv_pkg::WIN_B_HI);
	assign in_c    = (adc_sample > c_lo) && (adc_sample < c_hi);
	assign in_mid  = (adc_sample > akwv_pkg::WIN_MID_LO) && (adc_sample < akwv_pkg::WIN_MID_HI);

	always_comb begin
		cls.match = 1'b1;
		cls.key   = akwv_pkg::BTN_NONE;
		priority if (in_none) begin
			cls.key = akwv_pkg::BTN_NONE;
		end else if (in_a) begin
			cls.key = layout_select ? akwv_pkg::BTN_RIGHT : akwv_pkg::BTN_LEFT;
		end else if (in_low) begin
			cls.key = layout_select ? akwv_pkg::BTN_LEFT : akwv_pkg::BTN_RIGHT;
		end else if (in_b) begin
			cls.key = layout_select ? akwv_pkg::BTN_UP : akwv_pkg::BTN_DOWN;
		end else if (in_c) begin
			cls.key = layout_select ? akwv_pkg::BTN_DOWN : akwv_pkg::BTN_UP;
		end else if (in_mid) begin
			cls.key = akwv_pkg::BTN_MIDDLE;
		end else begin
			cls.match = 1'b0;
		end
	end

endmodule

FILE: src/akwv_vote.sv
// ----------------------------------------------------------------------------
// akwv_vote
// Held key, per-key saturating counters, millisecond timer and window vote.
// ----------------------------------------------------------------------------
module akwv_vote #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  akwv_pkg::class_t                   cls,
	input  logic                               ms_tick,
	input  logic [akwv_pkg::ELAPSED_WIDTH-1:0] window_ms,
	output akwv_pkg::result_t                  result
);

	akwv_pkg::key_t                     held_q;
	akwv_pkg::key_t                     held_nx;
	logic [COUNT_WIDTH-1:0]             counts_q   [akwv_pkg::NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0]             counts_inc [akwv_pkg::NUM_BUTTONS];
	logic [akwv_pkg::ELAPSED_WIDTH-1:0] elapsed_q;
	logic [akwv_pkg::ELAPSED_WIDTH-1:0] elapsed_inc;
	logic                               close;
	akwv_pkg::key_t                     w01, w23, w45, w03, winner;
	logic [COUNT_WIDTH-1:0]             c01, c23, c45, c03;

	assign held_nx = cls.match ? cls.key : held_q;

	always_comb begin
		for (int i = 0; i < akwv_pkg::NUM_BUTTONS; i++) begin
			counts_inc[i] = counts_q[i];
			if ((held_nx == akwv_pkg::key_t'(3'(i))) && (counts_q[i] != '1)) begin
				counts_inc[i] = counts_q[i] + COUNT_WIDTH'(1);
			end
		end
	end

	assign elapsed_inc = (ms_tick && (elapsed_q != '1))
		? elapsed_q + akwv_pkg::ELAPSED_WIDTH'(1) : elapsed_q;
	assign close = elapsed_inc > window_ms;

	// max tree, lower code wins ties
	always_comb begin
		w01 = (counts_inc[1] > counts_inc[0]) ? akwv_pkg::BTN_UP : akwv_pkg::BTN_NONE;
		c01 = (counts_inc[1] > counts_inc[0]) ? counts_inc[1] : counts_inc[0];
		w23 = (counts_inc[3] > counts_inc[2]) ? akwv_pkg::BTN_LEFT : akwv_pkg::BTN_DOWN;
		c23 = (counts_inc[3] > counts_inc[2]) ? counts_inc[3] : counts_inc[2];
		w45 = (counts_inc[5] > counts_inc[4]) ? akwv_pkg::BTN_MIDDLE : akwv_pkg::BTN_RIGHT;
		c45 = (counts_inc[5] > counts_inc[4]) ? counts_inc[5] : counts_inc[4];
		w03 = (c23 > c01) ? w23 : w01;
		c03 = (c23 > c01) ? c23 : c01;
		winner = (c45 > c03) ? w45 : w03;
	end

	always_comb begin
		result.event_valid = close && (winner != akwv_pkg::BTN_NONE);
		result.event_key   = result.event_valid ? winner : akwv_pkg::BTN_NONE;
		result.current_key = held_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= akwv_pkg::BTN_NONE;
			elapsed_q <= '0;
			for (int i = 0; i < akwv_pkg::NUM_BUTTONS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (step) begin
			held_q <= held_nx;
			if (close) begin
				elapsed_q <= '0;
				for (int i = 0; i < akwv_pkg::NUM_BUTTONS; i++) begin
					counts_q[i] <= '0;
				end
			end else begin
				elapsed_q <= elapsed_inc;
				for (int i = 0; i < akwv_pkg::NUM_BUTTONS; i++) begin
					counts_q[i] <= counts_inc[i];
				end
			end
		end
	end

endmodule

FILE: src/analog_keypad_window_vote.sv
// ----------------------------------------------------------------------------
// analog_keypad_window_vote
// A sample transfer lands in the input register, then its result lands in
// the result register once the output is free or taken. One sample per cycle
// unless result_ready stalls; set by the classify/count/max-tree vote path.
// Reset clears held key, counters, timer and both stage valid flags;
// layout_select is 0 and window_ms is 10.
// ----------------------------------------------------------------------------
module analog_keypad_window_vote #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [akwv_pkg::CFG_WIDTH-1:0] cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  akwv_pkg::sample_t              sample,
	output logic                           result_valid,
	input  logic                           result_ready,
	output akwv_pkg::result_t              result
);

	logic                               layout_q;
	logic [akwv_pkg::ELAPSED_WIDTH-1:0] window_q;
	logic                               valid_s1;
	akwv_pkg::sample_t                  sample_s1;
	logic                               advance;
	akwv_pkg::class_t                   cls;
	akwv_pkg::result_t                  result_nx;
	logic                               out_valid_q;
	akwv_pkg::result_t                  out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
			window_q <= akwv_pkg::WINDOW_MS_RESET;
		end else if (cfg_we) begin
			unique case (akwv_pkg::reg_index_t'(cfg_index))
				akwv_pkg::REG_LAYOUT_SELECT: layout_q <= cfg_data[0];
				akwv_pkg::REG_WINDOW_MS:     window_q <= cfg_data[akwv_pkg::ELAPSED_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	akwv_classify u_classify (
		.adc_sample    (sample_s1.adc_sample),
		.layout_select (layout_q),
		.cls           (cls)
	);

	akwv_vote #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_vote (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.cls       (cls),
		.ms_tick   (sample_s1.ms_tick),
		.window_ms (window_q),
		.result    (result_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result_nx;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
